@@ design/peu_pkg.sv @@
// shared types, constants and helpers for the particle euler update block
// no dependencies
`timescale 1ns / 1ps

package peu_pkg;

  localparam int unsigned PARTICLE_COUNT_DEF = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned PROD_W     = COORD_W + DT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN,
    CFG_BOX_MAX,
    CFG_DEF_VEL,
    CFG_DEF_ACC,
    CFG_FLOW
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FLOW_UP,
    FLOW_DOWN,
    FLOW_RIGHT,
    FLOW_LEFT
  } flow_e;

  typedef enum logic {
    MODE_INIT,
    MODE_STEP
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_ADDV,
    ST_MULV,
    ST_FIN
  } state_e;

  typedef logic [2:0][COORD_W-1:0] vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    vec_t pos;
    vec_t vel;
    vec_t acc;
  } entry_t;

  typedef struct packed {
    vec_t  box_min;
    vec_t  box_max;
    vec_t  def_vel;
    vec_t  def_acc;
    flow_e flow;
  } cfg_t;

  // coord + floor(prod / 2^16), saturated to 16 bits
  function automatic logic [COORD_W-1:0] add_sat(input logic [COORD_W-1:0] c,
                                                 input prod_t p);
    logic signed [COORD_W+1:0] s;
    s = $signed({{2{c[COORD_W-1]}}, c}) + $signed({p[PROD_W-1], p[PROD_W-1:DT_W]});
    if (s > $signed(18'sd32767)) begin
      return 16'h7fff;
    end else if (s < $signed(-18'sd32768)) begin
      return 16'h8000;
    end else begin
      return s[COORD_W-1:0];
    end
  endfunction

  function automatic prod_t mul_dt(input logic [COORD_W-1:0] c,
                                   input logic [DT_W-1:0] dt);
    return prod_t'($signed(c)) * prod_t'($signed({1'b0, dt}));
  endfunction

endpackage

@@ design/particle_euler_wrap_update_top.sv @@
// particle euler update with box respawn: config registers and core
// step request: read on accept, MULA, ADDV, MULV, then FIN writes and registers result
// init or out-of-range request: straight to FIN; FIN stalls while a result is unread
// one request at a time: particle memory read-modify-write with two chained multiplies
// reset clears config and control only; memory entries are undefined until init
`timescale 1ns / 1ps

module particle_euler_wrap_update_top #(
  parameter int unsigned PARTICLE_COUNT = peu_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [peu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [peu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [peu_pkg::IDX_W-1:0]         particle_index_i,
  input  logic [peu_pkg::DT_W-1:0]          delta_time_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [peu_pkg::IDX_W-1:0]         result_index_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_x_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_y_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_z_o,
  output logic                              respawned_o
);
  import peu_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BOX_MIN: cfg_d.box_min = cfg_data_i;
        CFG_BOX_MAX: cfg_d.box_max = cfg_data_i;
        CFG_DEF_VEL: cfg_d.def_vel = cfg_data_i;
        CFG_DEF_ACC: cfg_d.def_acc = cfg_data_i;
        CFG_FLOW:    cfg_d.flow    = flow_e'(cfg_data_i[1:0]);
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  peu_core #(
    .PARTICLE_COUNT (PARTICLE_COUNT)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .particle_index_i (particle_index_i),
    .delta_time_i     (delta_time_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .start_z_i        (start_z_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_index_o   (result_index_o),
    .position_x_o     (position_x_o),
    .position_y_o     (position_y_o),
    .position_z_o     (position_z_o),
    .respawned_o      (respawned_o)
  );

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a request is in flight");

  // a new result only comes from a request in flight
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no request in flight");

  // respawn with upward flow lands on the lower y face
  a_respawn_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && respawned_o && cfg_q.flow == FLOW_UP |-> position_y_o == cfg_q.box_min[1])
    else $error("respawned position not on the box face");

endmodule

@@ design/peu_state_mem.sv @@
// particle state memory: position, velocity and acceleration per entry
// one write port, one read port with registered data; uses peu_pkg
`timescale 1ns / 1ps

module peu_state_mem #(
  parameter int unsigned DEPTH = peu_pkg::PARTICLE_COUNT_DEF,
  parameter int unsigned AW    = 8
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output peu_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  peu_pkg::entry_t wr_data_i
);
  import peu_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/peu_core.sv @@
// sequencer and datapath: read entry, two euler multiply/add steps, box test,
// write back and output register; uses peu_pkg and peu_state_mem
`timescale 1ns / 1ps

module peu_core #(
  parameter int unsigned PARTICLE_COUNT = peu_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  peu_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [peu_pkg::IDX_W-1:0]     particle_index_i,
  input  logic [peu_pkg::DT_W-1:0]      delta_time_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [peu_pkg::COORD_W-1:0] start_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [peu_pkg::IDX_W-1:0]     result_index_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_x_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_y_o,
  output logic signed [peu_pkg::COORD_W-1:0] position_z_o,
  output logic                          respawned_o
);
  import peu_pkg::*;

  localparam int unsigned AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  state_e state_q, state_d;

  logic                accept;
  logic                fin_fire;
  logic                mem_we;
  logic                inrange;
  logic [AW+IDX_W-1:0] rd_idx_ext;
  logic [AW+IDX_W-1:0] wr_idx_ext;

  logic [IDX_W-1:0] idx_q;
  logic             mode_q;
  logic             inrange_q;
  logic [DT_W-1:0]  dt_q;
  vec_t             start_q;
  prod_t [2:0]      prod_q, prod_d;
  vec_t             vel_q, vel_d;

  entry_t rd_data;
  entry_t wr_data;
  vec_t   pos_step;
  vec_t   pos_fin;
  logic   outside;

  logic             out_valid_q;
  logic [IDX_W-1:0] res_idx_q;
  vec_t             res_pos_q;
  logic             res_resp_q;

  assign inrange    = 32'(particle_index_i) < PARTICLE_COUNT;
  assign rd_idx_ext = {{AW{1'b0}}, particle_index_i};
  assign wr_idx_ext = {{AW{1'b0}}, idx_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (mode_e'(mode_i) == MODE_STEP && inrange) ? ST_MULA : ST_FIN;
        end
      end
      ST_MULA: state_d = ST_ADDV;
      ST_ADDV: state_d = ST_MULV;
      ST_MULV: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    fin_fire   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_FIN:  fin_fire   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        fin_fire   = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign mem_we = fin_fire && inrange_q;

  // euler datapath
  always_comb begin
    prod_d = prod_q;
    vel_d  = vel_q;
    for (int k = 0; k < 3; k++) begin
      case (state_q)
        ST_MULA: prod_d[k] = mul_dt(rd_data.acc[k], dt_q);
        ST_ADDV: vel_d[k]  = add_sat(rd_data.vel[k], prod_q[k]);
        ST_MULV: prod_d[k] = mul_dt(vel_q[k], dt_q);
        default: begin
          prod_d[k] = prod_q[k];
          vel_d[k]  = vel_q[k];
        end
      endcase
    end
  end

  always_comb begin
    outside = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pos_step[k] = add_sat(rd_data.pos[k], prod_q[k]);
      if ($signed(pos_step[k]) < $signed(cfg_i.box_min[k]) ||
          $signed(pos_step[k]) > $signed(cfg_i.box_max[k])) begin
        outside = 1'b1;
      end
    end
    pos_fin = pos_step;
    if (outside) begin
      case (cfg_i.flow)
        FLOW_UP:    pos_fin[1] = cfg_i.box_min[1];
        FLOW_DOWN:  pos_fin[1] = cfg_i.box_max[1];
        FLOW_RIGHT: pos_fin[0] = cfg_i.box_min[0];
        default:    pos_fin[0] = cfg_i.box_max[0];
      endcase
    end
  end

  always_comb begin
    if (mode_e'(mode_q) == MODE_INIT) begin
      wr_data.pos = start_q;
      wr_data.vel = cfg_i.def_vel;
      wr_data.acc = cfg_i.def_acc;
    end else if (outside) begin
      wr_data.pos = pos_fin;
      wr_data.vel = cfg_i.def_vel;
      wr_data.acc = cfg_i.def_acc;
    end else begin
      wr_data.pos = pos_fin;
      wr_data.vel = vel_q;
      wr_data.acc = rd_data.acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    vel_q  <= vel_d;
    if (accept) begin
      idx_q     <= particle_index_i;
      mode_q    <= mode_i;
      inrange_q <= inrange;
      dt_q      <= delta_time_i;
      start_q   <= {start_z_i, start_y_i, start_x_i};
    end
    if (fin_fire) begin
      res_idx_q <= idx_q;
      if (!inrange_q) begin
        res_pos_q  <= '0;
        res_resp_q <= 1'b0;
      end else begin
        res_pos_q  <= wr_data.pos;
        res_resp_q <= (mode_e'(mode_q) == MODE_STEP) && outside;
      end
    end
  end

  peu_state_mem #(
    .DEPTH (PARTICLE_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_idx_ext[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (wr_idx_ext[AW-1:0]),
    .wr_data_i (wr_data)
  );

  assign out_valid_o    = out_valid_q;
  assign result_index_o = res_idx_q;
  assign position_x_o   = res_pos_q[0];
  assign position_y_o   = res_pos_q[1];
  assign position_z_o   = res_pos_q[2];
  assign respawned_o    = res_resp_q;

endmodule
